>>> hw/rtl/codon_translator_with_line_wrap_assert.svh
// ----------------------------------------------------------------------------
// Codon translator assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CODON_TRANSLATOR_WITH_LINE_WRAP_ASSERT_SVH
`define CODON_TRANSLATOR_WITH_LINE_WRAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTW_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ctw_pkg.sv
// ----------------------------------------------------------------------------
// Codon translator package
// Payload types, base decoding and the standard genetic code table.
// ----------------------------------------------------------------------------
package ctw_pkg;

  localparam int unsigned LineLenW = 16;

  localparam logic [2:0] UNKNOWN_CODE = 3'd4;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] UNKNOWN_CHAR = "X";

  typedef struct packed {
    logic [7:0] base_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] code;
    logic       last;
  } ctw_base_t;

  typedef struct packed {
    logic       newline;
    logic       emit;
    logic [7:0] residue;
    logic       last;
  } ctw_res_t;

  localparam logic [7:0] CODE_TABLE [64] = '{
    "K", "N", "K", "N", "T", "T", "T", "T", "R", "S", "R", "S", "I", "I", "M", "I",
    "Q", "H", "Q", "H", "P", "P", "P", "P", "R", "R", "R", "R", "L", "L", "L", "L",
    "E", "D", "E", "D", "A", "A", "A", "A", "G", "G", "G", "G", "V", "V", "V", "V",
    "*", "Y", "*", "Y", "S", "S", "S", "S", "*", "C", "W", "C", "L", "F", "L", "F"
  };

  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] code;
    case (c)
      "A", "a":           code = 3'd0;
      "C", "c":           code = 3'd1;
      "G", "g":           code = 3'd2;
      "T", "t", "U", "u": code = 3'd3;
      default:            code = UNKNOWN_CODE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] translate(input logic [2:0] a, input logic [2:0] b,
                                           input logic [2:0] c);
    logic [7:0] aa;
    if (a[2] || b[2] || c[2]) begin
      aa = UNKNOWN_CHAR;
    end else begin
      aa = CODE_TABLE[{a[1:0], b[1:0], c[1:0]}];
    end
    return aa;
  endfunction

endpackage

>>> hw/rtl/ctw_in_reg.sv
// ----------------------------------------------------------------------------
// Codon translator input register
// Decodes the incoming character and holds one base until the core takes it.
// ----------------------------------------------------------------------------
module ctw_in_reg import ctw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  input  logic      advance_i,
  output logic      item_valid_o,
  output ctw_base_t item_o
);

  logic      valid_q, valid_d;
  ctw_base_t item_q;
  logic      accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.code <= base_code(in_data_i.base_char);
      item_q.last <= in_data_i.is_last;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> hw/rtl/ctw_core.sv
// ----------------------------------------------------------------------------
// Codon translator core
// Codon assembly, translation and line-wrap counting for one base per cycle while advance_i is high.
// ----------------------------------------------------------------------------
module ctw_core import ctw_pkg::*; #(
  parameter int unsigned LINE_COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LineLenW-1:0] cfg_data_i,
  input  logic                advance_i,
  input  ctw_base_t           item_i,
  output ctw_res_t            res_o
);

  localparam int unsigned CmpW = (LINE_COUNT_BITS > LineLenW) ? LINE_COUNT_BITS : LineLenW;
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  logic [LineLenW-1:0]        wrap_len_q;
  logic [2:0]                 first_q, first_d;
  logic [2:0]                 second_q, second_d;
  logic [1:0]                 phase_q, phase_d;
  logic [LINE_COUNT_BITS-1:0] left_q, left_d;
  logic [LINE_COUNT_BITS-1:0] cnt_max, reload, left_base;
  logic [CmpW-1:0]            len_ext, max_ext;
  logic                       wrap_on;

  assign cnt_max = {LINE_COUNT_BITS{1'b1}};
  assign len_ext = CmpW'(wrap_len_q);
  assign max_ext = CmpW'(cnt_max);
  assign reload  = (len_ext > max_ext) ? cnt_max : LINE_COUNT_BITS'(len_ext);
  assign wrap_on = (wrap_len_q != '0);
  assign left_base = (left_q == '0) ? reload : left_q;

  always_comb begin
    first_d       = first_q;
    second_d      = second_q;
    phase_d       = phase_q;
    left_d        = left_q;
    res_o.emit    = item_i.last;
    res_o.residue = UNKNOWN_CHAR;
    res_o.last    = item_i.last;
    case (phase_q)
      PHASE_ONE: begin
        second_d = item_i.code;
        phase_d  = PHASE_TWO;
      end
      PHASE_TWO: begin
        res_o.emit    = 1'b1;
        res_o.residue = translate(first_q, second_q, item_i.code);
        phase_d       = PHASE_NONE;
      end
      default: begin
        first_d = item_i.code;
        phase_d = PHASE_ONE;
      end
    endcase
    res_o.newline = res_o.emit && wrap_on && (left_q == '0);
    if (res_o.emit && wrap_on) begin
      left_d = left_base - LINE_COUNT_BITS'(1);
    end
    if (item_i.last) begin
      phase_d = PHASE_NONE;
      left_d  = reload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_len_q <= '0;
      phase_q    <= PHASE_NONE;
      left_q     <= '0;
      first_q    <= '0;
      second_q   <= '0;
    end else if (cfg_we_i) begin
      wrap_len_q <= cfg_data_i;
      left_q     <= ((CmpW'(cfg_data_i)) > max_ext) ? cnt_max
                                                    : LINE_COUNT_BITS'(CmpW'(cfg_data_i));
    end else if (advance_i) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

>>> hw/rtl/ctw_out_buf.sv
// ----------------------------------------------------------------------------
// Codon translator result register
// Holds an optional newline and one residue, sent newline first.
// ----------------------------------------------------------------------------
module ctw_out_buf import ctw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  ctw_res_t  res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       nl_q, nl_d;
  logic       res_q, res_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       xfer;

  assign out_valid_o = nl_q || res_q;
  assign xfer        = out_valid_o && !out_stall_i;
  assign free_o      = !out_valid_o || (xfer && !nl_q);

  always_comb begin
    nl_d  = nl_q;
    res_d = res_q;
    if (load_i) begin
      nl_d  = res_i.newline;
      res_d = res_i.emit;
    end else if (xfer) begin
      if (nl_q) begin
        nl_d = 1'b0;
      end else begin
        res_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q  <= 1'b0;
      res_q <= 1'b0;
    end else begin
      nl_q  <= nl_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= res_i.residue;
      last_q <= res_i.last;
    end
  end

  assign out_data_o.out_char = nl_q ? NEWLINE_CHAR : char_q;
  assign out_data_o.out_last = !nl_q && last_q;

endmodule

>>> hw/rtl/codon_translator_with_line_wrap.sv
// ----------------------------------------------------------------------------
// Codon translator with line wrap
// Path: an accepted base is registered in the input register, its result in the result register.
// Throughput: one base per cycle; a base that yields a residue waits while the
// result register still holds a result after this cycle (output stall, newline).
// Reset: clears handshake state, codon phase, line length and line counter.
// ----------------------------------------------------------------------------
`include "codon_translator_with_line_wrap_assert.svh"

module codon_translator_with_line_wrap import ctw_pkg::*; #(
  parameter int unsigned LINE_COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [LineLenW-1:0] cfg_data_i
);

  logic      item_valid;
  ctw_base_t item;
  logic      out_free;
  logic      advance;
  logic      load;
  ctw_res_t  res;
  logic      out_is_nl;

  assign advance   = item_valid && (out_free || !res.emit);
  assign load      = advance && res.emit;
  assign out_is_nl = out_valid_o && (out_data_o.out_char == NEWLINE_CHAR);

  ctw_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ctw_core #(
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .item_i     (item),
    .res_o      (res)
  );

  ctw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `CTW_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o, "stall without result")
  `CTW_ASSERT_NOW(a_newline_not_last, out_is_nl, !out_data_o.out_last, "newline flagged last")
  `CTW_ASSERT_NEXT(a_newline_then_residue, out_is_nl && !out_stall_i, out_valid_o, "lone newline")

endmodule

>>> tb/tb_codon_translator_with_line_wrap.sv
// ----------------------------------------------------------------------------
// Codon translator with line wrap testbench
// Streams nucleotide sequences into the translator under several line
// lengths. A built-in predictor computes the expected residues and line
// breaks, and each output transfer is checked against them in order. Both
// sides idle at random, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_codon_translator_with_line_wrap;
  import ctw_pkg::*;

  localparam logic [8*64-1:0] AMINO_ACIDS = {
    "KNKNTTTTRSRSIIMI", "QHQHPPPPRRRRLLLL", "EDEDAAAAGGGGVVVV", "*Y*YSSSS*CWCLFLF"
  };
  localparam logic [8*10-1:0] NUCLEOTIDES = "ACGTUacgtu";
  localparam int DRAIN_CYCLES = 8;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  in_item_t      in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  out_item_t     out_data_o;
  logic          cfg_we_i;
  logic [LineLenW-1:0] cfg_data_i;

  out_item_t     pending_residues [$];
  out_item_t     want;

  logic [15:0]   wrap_len;
  logic [15:0]   residues_left;
  logic [2:0]    first_code;
  logic [2:0]    second_code;
  logic [1:0]    codon_phase;

  bit            no_gaps;
  int            hold_cycles;
  int            errors;
  int            bases_sent;
  int            sequences_sent;
  int            results_checked;
  int            newlines_checked;
  int            settings_used;
  int            input_stall_cycles;

  codon_translator_with_line_wrap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_codon_translator_with_line_wrap NOT OK");
    $finish;
  end

  function automatic logic [2:0] decode_base(logic [7:0] ch);
    logic [2:0] code;
    case (ch & 8'hDF)
      "A": code = 3'd0;
      "C": code = 3'd1;
      "G": code = 3'd2;
      "T", "U": code = 3'd3;
      default: code = UNKNOWN_CODE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] amino_acid(logic [2:0] a, logic [2:0] b, logic [2:0] c);
    int idx;
    if (a > 3'd3 || b > 3'd3 || c > 3'd3) begin
      return "X";
    end
    idx = int'({a[1:0], b[1:0], c[1:0]});
    return AMINO_ACIDS[8*(63-idx) +: 8];
  endfunction

  function automatic logic [7:0] random_base();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return NUCLEOTIDES[8*$urandom_range(0, 9) +: 8];
  endfunction

  task automatic predict_residues(input in_item_t item);
    logic [2:0] code;
    logic       emit;
    logic [7:0] residue;
    code    = decode_base(item.base_char);
    emit    = 1'b0;
    residue = "X";
    case (codon_phase)
      2'd2: begin
        emit        = 1'b1;
        residue     = amino_acid(first_code, second_code, code);
        codon_phase = 2'd0;
      end
      2'd1: begin
        if (item.is_last) begin
          emit = 1'b1;
        end else begin
          second_code = code;
          codon_phase = 2'd2;
        end
      end
      default: begin
        if (item.is_last) begin
          emit = 1'b1;
        end else begin
          first_code  = code;
          codon_phase = 2'd1;
        end
      end
    endcase
    if (emit) begin
      if (wrap_len != 16'd0) begin
        if (residues_left == 16'd0) begin
          pending_residues.push_back('{out_char: NEWLINE_CHAR, out_last: 1'b0});
          residues_left = wrap_len;
        end
        residues_left = residues_left - 16'd1;
      end
      pending_residues.push_back('{out_char: residue, out_last: item.is_last});
    end
    if (item.is_last) begin
      codon_phase   = 2'd0;
      residues_left = wrap_len;
      sequences_sent++;
    end
  endtask

  task automatic send_base(input logic [7:0] ch, input logic last);
    in_item_t item;
    item.base_char = ch;
    item.is_last   = last;
    while (!no_gaps && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) begin
        break;
      end
      input_stall_cycles++;
    end
    predict_residues(item);
    bases_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_base(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_sequence(input int len);
    for (int i = 0; i < len; i++) begin
      send_base(random_base(), i == len - 1);
    end
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_residues.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_line_length(input logic [15:0] value);
    wait_for_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    wrap_len      = value;
    residues_left = value;
    settings_used++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_residues.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                 $time, out_data_o.out_char, out_data_o.out_last);
        errors++;
      end else begin
        want = pending_residues.pop_front();
        if (out_data_o.out_char !== want.out_char) begin
          $display("%0t: out_char mismatch, expected %h actual %h",
                   $time, want.out_char, out_data_o.out_char);
          errors++;
        end
        if (out_data_o.out_last !== want.out_last) begin
          $display("%0t: out_last mismatch, expected %b actual %b",
                   $time, want.out_last, out_data_o.out_last);
          errors++;
        end
        results_checked++;
        if (want.out_char == NEWLINE_CHAR) begin
          newlines_checked++;
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 9);
      end
    end
  end

  task automatic test_directed_codons();
    send_string("ATG", 1'b0);
    send_string("TAA", 1'b0);
    send_string("uga", 1'b0);
    send_string("tgG", 1'b0);
    send_base(8'h00, 1'b0);
    send_base(8'hFF, 1'b0);
    send_base("A", 1'b0);
    send_string("cU", 1'b1);
    send_base(8'h80, 1'b1);
    send_string("GCa", 1'b1);
  endtask

  task automatic test_wrap_directed();
    set_line_length(16'd2);
    send_string("AAAcccG", 1'b1);
    set_line_length(16'd1);
    send_string("TTTggg", 1'b1);
  endtask

  task automatic test_random_line_lengths();
    logic [15:0] lengths [8];
    int          budget;
    int          len;
    lengths = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd64, 16'hFFFF, 16'd0};
    lengths[7] = 16'($urandom_range(4, 65534));
    foreach (lengths[k]) begin
      set_line_length(lengths[k]);
      budget = 60;
      while (budget > 0) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        send_sequence(len);
        budget -= len;
      end
    end
  endtask

  task automatic test_output_hold_off();
    set_line_length(16'd4);
    hold_cycles = 60;
    send_sequence(45);
  endtask

  task automatic test_steady_stream();
    set_line_length(16'd3);
    no_gaps = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_sequence($urandom_range(18, 30));
    end
    wait_for_idle();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    wrap_len      = 16'd0;
    residues_left = 16'd0;
    first_code    = 3'd0;
    second_code   = 3'd0;
    codon_phase   = 2'd0;
    no_gaps       = 1'b0;
    hold_cycles   = 0;
    errors        = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_codons();
    test_wrap_directed();
    test_random_line_lengths();
    test_output_hold_off();
    test_steady_stream();
    wait_for_idle();

    $display("Run covered %0d bases in %0d sequences under %0d line-length writes",
             bases_sent, sequences_sent, settings_used);
    $display("Checked %0d results (%0d line breaks); input held off for %0d cycles",
             results_checked, newlines_checked, input_stall_cycles);
    if (errors == 0 && pending_residues.size() == 0) begin
      $display("tb_codon_translator_with_line_wrap OK");
    end else begin
      $display("tb_codon_translator_with_line_wrap NOT OK");
    end
    $finish;
  end

endmodule
